### design/ase_pkg.sv
// Shared constants, register codes and tables for the additive SE kernel entry block.
package ase_pkg;

    // Number of coordinate lanes carried by one transaction.
    localparam int LANES = 4;
    // Number of dimensions the block may sum.
    localparam int DIMS = 4;

    // Taylor terms for exp(-f) and stages of the exp(-1) chain.
    localparam int TAYLOR_TERMS = 9;
    localparam int EXP_STEPS = 15;

    // exp(-1) in Q0.32.
    localparam logic [30:0] EXP_NEG_ONE_Q32 = 31'd1580030169;

    // Pipeline depths.
    localparam int LANE_FRONT_LAT = 4;
    localparam int EXP_LAT = 3 * TAYLOR_TERMS + EXP_STEPS + 1;
    localparam int PIPE_LAT = LANE_FRONT_LAT + EXP_LAT + 1;

    // Register indexes, paddr[5:3].
    localparam logic [2:0] REG_H01 = 3'd0;
    localparam logic [2:0] REG_H23 = 3'd1;
    localparam logic [2:0] REG_SV01 = 3'd2;
    localparam logic [2:0] REG_SV23 = 3'd3;
    localparam logic [2:0] REG_NOISE = 3'd4;
    localparam logic [2:0] REG_DIMS = 3'd5;

    // floor(2^32 / k) for the reciprocal divide; k of one is a plain pass.
    function automatic logic [31:0] recip_q32(input int k);
        logic [31:0] m;
        begin
            case (k)
                2: m = 32'd2147483648;
                3: m = 32'd1431655765;
                4: m = 32'd1073741824;
                5: m = 32'd858993459;
                6: m = 32'd715827882;
                7: m = 32'd613566756;
                8: m = 32'd536870912;
                9: m = 32'd477218588;
                default: m = 32'd0;
            endcase
            return m;
        end
    endfunction

endpackage

### design/ase_exp.sv
// Pipelined exp(-t) in Q0.16: Taylor series for the fraction, then the exp(-1) chain.
module ase_exp import ase_pkg::*; (
    input  logic        i_clk,
    input  logic        i_adv,
    input  logic        i_zero,
    input  logic [3:0]  i_n,
    input  logic [15:0] i_f,
    output logic [16:0] o_e
);

    // Taylor step k: A multiplies, B takes the reciprocal, C corrects and accumulates
    logic [48:0] r_a_prod [1:TAYLOR_TERMS];
    logic [32:0] r_a_sum  [1:TAYLOR_TERMS];
    logic [15:0] r_a_f    [1:TAYLOR_TERMS];
    logic [3:0]  r_a_n    [1:TAYLOR_TERMS];
    logic        r_a_z    [1:TAYLOR_TERMS];

    logic [31:0] r_b_x    [1:TAYLOR_TERMS];
    logic [31:0] r_b_q0   [1:TAYLOR_TERMS];
    logic [32:0] r_b_sum  [1:TAYLOR_TERMS];
    logic [15:0] r_b_f    [1:TAYLOR_TERMS];
    logic [3:0]  r_b_n    [1:TAYLOR_TERMS];
    logic        r_b_z    [1:TAYLOR_TERMS];

    logic [32:0] r_c_term [1:TAYLOR_TERMS];
    logic [32:0] r_c_sum  [1:TAYLOR_TERMS];
    logic [15:0] r_c_f    [1:TAYLOR_TERMS];
    logic [3:0]  r_c_n    [1:TAYLOR_TERMS];
    logic        r_c_z    [1:TAYLOR_TERMS];

    // exp(-1) chain
    logic [32:0] r_e_sum  [0:EXP_STEPS-1];
    logic [3:0]  r_e_n    [0:EXP_STEPS-1];
    logic        r_e_z    [0:EXP_STEPS-1];

    logic [16:0] r_round;

    for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_tay
        logic [32:0] term_in;
        logic [32:0] sum_in;
        logic [15:0] f_in;
        logic [3:0]  n_in;
        logic        z_in;
        logic [31:0] n_x;
        logic [31:0] n_q0;
        logic [31:0] rem;
        logic [31:0] quo;

        if (k == 1) begin : g_first
            assign term_in = 33'h1_0000_0000;
            assign sum_in  = 33'h1_0000_0000;
            assign f_in    = i_f;
            assign n_in    = i_n;
            assign z_in    = i_zero;
        end else begin : g_next
            assign term_in = r_c_term[k-1];
            assign sum_in  = r_c_sum[k-1];
            assign f_in    = r_c_f[k-1];
            assign n_in    = r_c_n[k-1];
            assign z_in    = r_c_z[k-1];
        end

        // term * f, the shift right 16 happens in B
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_a_prod[k] <= 49'(term_in) * 49'(f_in);
                r_a_sum[k]  <= sum_in;
                r_a_f[k]    <= f_in;
                r_a_n[k]    <= n_in;
                r_a_z[k]    <= z_in;
            end
        end

        // quotient estimate, low by at most one
        assign n_x = r_a_prod[k][47:16];
        if (k == 1) begin : g_nodiv
            assign n_q0 = n_x;
        end else begin : g_div
            assign n_q0 = 32'((64'(n_x) * 64'(recip_q32(k))) >> 32);
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_b_x[k]   <= n_x;
                r_b_q0[k]  <= n_q0;
                r_b_sum[k] <= r_a_sum[k];
                r_b_f[k]   <= r_a_f[k];
                r_b_n[k]   <= r_a_n[k];
                r_b_z[k]   <= r_a_z[k];
            end
        end

        // correct the estimate, then add or subtract the term
        assign rem = r_b_x[k] - 32'(r_b_q0[k] * 32'(k));
        assign quo = (rem >= 32'(k)) ? r_b_q0[k] + 32'd1 : r_b_q0[k];

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_c_term[k] <= {1'b0, quo};
                if ((k % 2) == 1) begin
                    r_c_sum[k] <= r_b_sum[k] - {1'b0, quo};
                end else begin
                    r_c_sum[k] <= r_b_sum[k] + {1'b0, quo};
                end
                r_c_f[k] <= r_b_f[k];
                r_c_n[k] <= r_b_n[k];
                r_c_z[k] <= r_b_z[k];
            end
        end
    end

    for (genvar j = 0; j < EXP_STEPS; j++) begin : g_e1
        logic [32:0] sum_in;
        logic [3:0]  n_in;
        logic        z_in;
        logic [63:0] prod;

        if (j == 0) begin : g_first
            assign sum_in = r_c_sum[TAYLOR_TERMS];
            assign n_in   = r_c_n[TAYLOR_TERMS];
            assign z_in   = r_c_z[TAYLOR_TERMS];
        end else begin : g_next
            assign sum_in = r_e_sum[j-1];
            assign n_in   = r_e_n[j-1];
            assign z_in   = r_e_z[j-1];
        end

        // one more factor of exp(-1) while the integer part asks for it
        assign prod = 64'(sum_in) * 64'(EXP_NEG_ONE_Q32);

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (n_in > 4'(j)) begin
                    r_e_sum[j] <= 33'((prod + 64'h8000_0000) >> 32);
                end else begin
                    r_e_sum[j] <= sum_in;
                end
                r_e_n[j] <= n_in;
                r_e_z[j] <= z_in;
            end
        end
    end

    // round Q0.32 to Q0.16; large arguments give zero
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (r_e_z[EXP_STEPS-1]) begin
                r_round <= '0;
            end else begin
                r_round <= 17'((r_e_sum[EXP_STEPS-1] + 33'h8000) >> 16);
            end
        end
    end

    assign o_e = r_round;

endmodule

### design/ase_lane.sv
// One dimension lane: squared distance scaled by h, then exp(-t).
module ase_lane import ase_pkg::*; (
    input  logic               i_clk,
    input  logic               i_adv,
    input  logic signed [15:0] i_xa,
    input  logic signed [15:0] i_xb,
    input  logic [31:0]        i_h,
    output logic [16:0]        o_e
);

    logic signed [16:0] diff;
    logic [15:0]        n_mag;
    logic [15:0]        r_mag;
    logic [31:0]        r_sq;
    logic [63:0]        r_p;
    logic               r_zero;
    logic [3:0]         r_n;
    logic [15:0]        r_f;

    // exact difference and magnitude
    assign diff  = {i_xa[15], i_xa} - {i_xb[15], i_xb};
    assign n_mag = diff[16] ? 16'(-diff) : diff[15:0];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mag  <= n_mag;
            r_sq   <= 32'(r_mag) * 32'(r_mag);
            r_p    <= 64'(r_sq) * 64'(i_h);
            // t of 16 or more gives zero
            r_zero <= |r_p[63:36];
            r_n    <= r_p[35:32];
            r_f    <= r_p[31:16];
        end
    end

    ase_exp u_exp (
        .i_clk  (i_clk),
        .i_adv  (i_adv),
        .i_zero (r_zero),
        .i_n    (r_n),
        .i_f    (r_f),
        .o_e    (o_e)
    );

endmodule

### design/additive_se_kernel_entry_top.sv
// Throughput: one transaction per cycle; the 48-stage pipeline and output register
// advance together whenever the output register is empty or not stalled.
// Reset (synchronous, active low) clears the valid bits and loads the register
// defaults: h = 0.5, signal variance = 1.0, noise = 0, dims_used = 4.
// Top level of the additive SE kernel entry block.
module additive_se_kernel_entry_top import ase_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_xa_0,
    input  logic signed [15:0] i_xa_1,
    input  logic signed [15:0] i_xa_2,
    input  logic signed [15:0] i_xa_3,
    input  logic signed [15:0] i_xb_0,
    input  logic signed [15:0] i_xb_1,
    input  logic signed [15:0] i_xb_2,
    input  logic signed [15:0] i_xb_3,
    input  logic               i_same_point,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_kernel_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [31:0] r_h     [0:LANES-1];
    logic [31:0] r_sv    [0:LANES-1];
    logic [31:0] r_noise;
    logic [2:0]  r_dims;

    logic        adv;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic [2:0]  count;

    logic signed [15:0] xa [0:LANES-1];
    logic signed [15:0] xb [0:LANES-1];
    logic [16:0] lane_e  [0:LANES-1];
    logic [32:0] r_term  [0:LANES-1];

    logic        r_vld [0:PIPE_LAT-1];
    logic        r_sp  [0:PIPE_LAT-1];
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [34:0] acc;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < LANES; d++) begin
                r_h[d]  <= 32'h0000_8000;
                r_sv[d] <= 32'h0001_0000;
            end
            r_noise <= '0;
            r_dims  <= 3'd4;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_H01: begin
                    r_h[0] <= pwdata[31:0];
                    r_h[1] <= pwdata[63:32];
                end
                REG_H23: begin
                    r_h[2] <= pwdata[31:0];
                    r_h[3] <= pwdata[63:32];
                end
                REG_SV01: begin
                    r_sv[0] <= pwdata[31:0];
                    r_sv[1] <= pwdata[63:32];
                end
                REG_SV23: begin
                    r_sv[2] <= pwdata[31:0];
                    r_sv[3] <= pwdata[63:32];
                end
                REG_NOISE: r_noise <= pwdata[31:0];
                REG_DIMS:  r_dims  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_H01:   prdata = {r_h[1], r_h[0]};
            REG_H23:   prdata = {r_h[3], r_h[2]};
            REG_SV01:  prdata = {r_sv[1], r_sv[0]};
            REG_SV23:  prdata = {r_sv[3], r_sv[2]};
            REG_NOISE: prdata = {32'd0, r_noise};
            REG_DIMS:  prdata = {61'd0, r_dims};
            default:   prdata = '0;
        endcase
    end

    // whole pipeline moves when the output register can take a value
    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    assign xa[0] = i_xa_0;
    assign xa[1] = i_xa_1;
    assign xa[2] = i_xa_2;
    assign xa[3] = i_xa_3;
    assign xb[0] = i_xb_0;
    assign xb[1] = i_xb_1;
    assign xb[2] = i_xb_2;
    assign xb[3] = i_xb_3;

    for (genvar d = 0; d < LANES; d++) begin : g_lane
        ase_lane u_lane (
            .i_clk (i_clk),
            .i_adv (adv),
            .i_xa  (xa[d]),
            .i_xb  (xb[d]),
            .i_h   (r_h[d]),
            .o_e   (lane_e[d])
        );

        // sv * e rounded to Q16.16
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_term[d] <= 33'(((49'(r_sv[d]) * 49'(lane_e[d])) + 49'h8000) >> 16);
            end
        end
    end

    // valid and same-point flag travel beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIPE_LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < PIPE_LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_valid <= r_vld[PIPE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sp[0] <= i_same_point;
            for (int s = 1; s < PIPE_LAT; s++) begin
                r_sp[s] <= r_sp[s-1];
            end
        end
    end

    // dimensions summed, clamped to what is built
    always_comb begin
        count = r_dims;
        if (count > 3'(DIMS)) begin
            count = 3'(DIMS);
        end
        if (count > 3'(LANES)) begin
            count = 3'(LANES);
        end
    end

    // sum of terms plus noise, saturated
    always_comb begin
        acc = '0;
        for (int d = 0; d < LANES; d++) begin
            if (3'(d) < count) begin
                acc = acc + 35'(r_term[d]);
            end
        end
        if (r_sp[PIPE_LAT-1]) begin
            acc = acc + 35'(r_noise);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= (|acc[34:32]) ? 32'hFFFF_FFFF : acc[31:0];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kernel_value = r_out_data;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("input stalled with free output register");

    a_bubble_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_stall && !r_vld[PIPE_LAT-1]) |=> !o_valid)
        else $error("transaction invented at output");

endmodule

### tb/ase_kernel_checker.sv
// Kernel entry checker: watches both channels, predicts each entry and compares.
`timescale 1ns / 100ps
module ase_kernel_checker import ase_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] xa [LANES],
    input  logic signed [15:0] xb [LANES],
    input  logic               same_point,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [31:0]        kernel_value,
    // configuration mirror, written by the stimulus side
    input  logic [31:0]        h_cfg [LANES],
    input  logic [31:0]        sv_cfg [LANES],
    input  logic [31:0]        noise_cfg,
    input  logic [2:0]         dims_cfg,
    output int                 fail_count,
    output int                 pending
);

    logic [31:0] entry_q[$];

    // exp(-(n + f/2^16)) in Q0.16
    function automatic logic [31:0] exp_neg(input logic [31:0] n, input logic [15:0] f);
        logic [63:0] term;
        logic [63:0] acc;
        begin
            term = 64'd1 << 32;
            acc = 64'd1 << 32;
            for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                term = ((term * f) >> 16) / k;
                if (k % 2) acc = acc - term;
                else acc = acc + term;
            end
            for (int k = 0; k < n; k++)
                acc = (acc * 64'd1580030169 + 64'h8000_0000) >> 32;
            return 32'((acc + 64'h8000) >> 16);
        end
    endfunction

    function automatic logic [31:0] kernel_entry();
        int          count;
        logic [63:0] acc;
        logic [31:0] mag;
        logic [63:0] prod;
        logic [31:0] t;
        logic [31:0] e;
        int          diff;
        begin
            count = int'(dims_cfg);
            if (count > DIMS) count = DIMS;
            if (count > LANES) count = LANES;
            acc = 0;
            for (int d = 0; d < count; d++) begin
                diff = int'(xa[d]) - int'(xb[d]);
                mag = diff < 0 ? -diff : diff;
                prod = 64'(mag * mag) * h_cfg[d];
                if (prod >= 64'd68719476736) begin
                    e = 0;
                end else begin
                    t = 32'(prod >> 16);
                    e = exp_neg(t >> 16, t[15:0]);
                end
                acc = acc + ((64'(sv_cfg[d]) * e + 64'h8000) >> 16);
            end
            if (same_point) acc = acc + noise_cfg;
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
            return acc[31:0];
        end
    endfunction

    assign pending = entry_q.size();

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (in_valid && !in_stall) entry_q.push_back(kernel_entry());
            if (out_valid && !out_stall) begin
                if (entry_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result %h", kernel_value);
                    fail_count <= fail_count + 1;
                end else begin
                    want = entry_q.pop_front();
                    if (want !== kernel_value) begin
                        if (fail_count < 10)
                            $display("kernel_value mismatch: expected %h got %h",
                                     want, kernel_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/tb.sv
// Stimulus and verdict for the additive SE kernel entry block.
`timescale 1ns / 100ps
module tb;
    import ase_pkg::*;

    localparam int WATCHDOG = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] xa [LANES];
    logic signed [15:0] xb [LANES];
    logic               i_same_point;
    logic               o_valid;
    logic               i_stall;
    logic [31:0]        o_kernel_value;
    logic               psel, penable, pwrite;
    logic [5:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    logic [31:0] h_cfg [LANES];
    logic [31:0] sv_cfg [LANES];
    logic [31:0] noise_cfg;
    logic [2:0]  dims_cfg;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          quiet;

    additive_se_kernel_entry_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_xa_0(xa[0]), .i_xa_1(xa[1]), .i_xa_2(xa[2]), .i_xa_3(xa[3]),
        .i_xb_0(xb[0]), .i_xb_1(xb[1]), .i_xb_2(xb[2]), .i_xb_3(xb[3]),
        .i_same_point(i_same_point), .o_valid(o_valid), .i_stall(i_stall),
        .o_kernel_value(o_kernel_value), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    ase_kernel_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(i_valid), .in_stall(o_stall),
        .xa(xa), .xb(xb), .same_point(i_same_point), .out_valid(o_valid),
        .out_stall(i_stall), .kernel_value(o_kernel_value), .h_cfg(h_cfg),
        .sv_cfg(sv_cfg), .noise_cfg(noise_cfg), .dims_cfg(dims_cfg),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial begin
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall <= 1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_stall <= 0;
            end
        end
    end

    // register write, mirror updated in step with the block
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 3'b000}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        case (idx)
            REG_H01:   begin h_cfg[0] = value[31:0]; h_cfg[1] = value[63:32]; end
            REG_H23:   begin h_cfg[2] = value[31:0]; h_cfg[3] = value[63:32]; end
            REG_SV01:  begin sv_cfg[0] = value[31:0]; sv_cfg[1] = value[63:32]; end
            REG_SV23:  begin sv_cfg[2] = value[31:0]; sv_cfg[3] = value[63:32]; end
            REG_NOISE: noise_cfg = value[31:0];
            REG_DIMS:  dims_cfg = value[2:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // one input transaction; held until accepted, valid drops only for a gap or a drain
    task automatic send_pair(input logic [15:0] a [LANES], input logic [15:0] b [LANES],
                             input logic same, input bit gaps);
        if (gaps && !quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        for (int d = 0; d < LANES; d++) begin
            xa[d] <= a[d];
            xb[d] <= b[d];
        end
        i_same_point <= same;
        i_valid <= 1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 5) @(negedge i_clk);
    endtask

    // random coordinate: mostly near pairs so the exponential is not always zero
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($signed($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    task automatic random_pairs(input int count);
        logic [15:0] a [LANES];
        logic [15:0] b [LANES];
        for (int i = 0; i < count; i++) begin
            for (int d = 0; d < LANES; d++) begin
                a[d] = rand_coord();
                b[d] = $urandom_range(0, 2) == 0 ? rand_coord()
                       : a[d] + 16'($signed($urandom_range(0, 1024)) - 512);
            end
            send_pair(a, b, 1'($urandom_range(0, 1)), 1);
        end
    endtask

    function automatic logic [31:0] rand_h();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 65536));
            1: return 32'($urandom_range(0, 512));
            2: return $urandom;
            default: return 32'h8000;
        endcase
    endfunction

    initial begin
        logic [15:0] a [LANES];
        logic [15:0] b [LANES];
        quiet = 0;
        i_rst_n = 0; i_valid = 0; i_same_point = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        for (int d = 0; d < LANES; d++) begin
            xa[d] = 0; xb[d] = 0;
            h_cfg[d] = 32'h8000; sv_cfg[d] = 32'h10000;
        end
        noise_cfg = 0; dims_cfg = 4;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: reset settings, same point, extremes
        for (int d = 0; d < LANES; d++) begin a[d] = 16'h0; b[d] = 16'h0; end
        send_pair(a, b, 0, 0);
        send_pair(a, b, 1, 0);
        for (int d = 0; d < LANES; d++) begin a[d] = 16'h7FFF; b[d] = 16'h8000; end
        send_pair(a, b, 1, 0);
        send_pair(b, a, 0, 0);
        for (int d = 0; d < LANES; d++) begin a[d] = 16'(256 * d); b[d] = 16'h0; end
        send_pair(a, b, 0, 0);
        for (int d = 0; d < LANES; d++) begin a[d] = 16'hFFFF; b[d] = 16'h0000; end
        send_pair(a, b, 0, 0);
        drain();

        // saturation, wide values, h extremes
        reg_write(REG_SV01, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(REG_SV23, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(REG_NOISE, 64'h0000_0000_FFFF_FFFF);
        reg_write(REG_H01, 64'h0);
        reg_write(REG_H23, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int d = 0; d < LANES; d++) begin a[d] = 16'h0040; b[d] = 16'h0; end
        send_pair(a, b, 1, 0);
        send_pair(a, b, 0, 0);
        for (int d = 0; d < LANES; d++) begin a[d] = 16'h0; b[d] = 16'h0; end
        send_pair(a, b, 0, 0);
        drain();

        // no dimensions and clamped dimensions
        reg_write(REG_DIMS, 64'd0);
        send_pair(a, b, 1, 0);
        send_pair(a, b, 0, 0);
        drain();
        reg_write(REG_DIMS, 64'd7);
        send_pair(a, b, 0, 0);
        drain();

        // random phases under varied settings
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(REG_H01, {rand_h(), rand_h()});
            reg_write(REG_H23, {rand_h(), rand_h()});
            reg_write(REG_SV01, {$urandom_range(0, 1) ? $urandom : 32'h10000,
                                 32'($urandom_range(0, 262144))});
            reg_write(REG_SV23, {32'($urandom_range(0, 262144)), $urandom});
            reg_write(REG_NOISE, {32'd0, $urandom_range(0, 1) ? $urandom
                                         : 32'($urandom_range(0, 70000))});
            reg_write(REG_DIMS, 64'($urandom_range(0, 7)));
            if (ph == 7) quiet = 1;
            random_pairs(150);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### additive_se_kernel_entry_top.f
design/ase_pkg.sv
design/ase_exp.sv
design/ase_lane.sv
design/additive_se_kernel_entry_top.sv
tb/ase_kernel_checker.sv
tb/tb.sv
